>>> rtl/spr_pkg.sv
package spr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int MAX_MULT_DEF   = 16;

    localparam int ROW_W      = 15;
    localparam int ROW_MAX    = 32767;
    localparam int IDX_W      = 20;
    localparam int MULT_REG_W = 5;
    localparam int SHIFT_W    = 8;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_MEASURE = 2'd1,
        OP_EMIT    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_XMIN  = 3'd0,
        REG_YMIN  = 3'd1,
        REG_COLS  = 3'd2,
        REG_MULT  = 3'd3,
        REG_INV   = 3'd4,
        REG_SHIFT = 3'd5
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_LOC,
        ST_BOX,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic step;
        t_op  op;
        logic valid;
    } t_box_cmd;

endpackage

>>> rtl/spr_if.sv
interface spr_in_if import spr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [IDX_W-1:0]      user_index;

    modport source (output valid, output opcode, output pixel_x, output pixel_y,
                    output user_index, input ready);
    modport sink   (input valid, input opcode, input pixel_x, input pixel_y,
                    input user_index, output ready);
endinterface

interface spr_out_if import spr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  written;
    logic [ROW_W-1:0]      map_row;
    logic [COORD_BITS-1:0] map_col;
    logic [IDX_W-1:0]      mapped_index;
    logic [ROW_W-1:0]      box_rows;
    logic [COORD_BITS:0]   box_cols;
    logic                  config_error;

    modport source (output valid, output written, output map_row, output map_col,
                    output mapped_index, output box_rows, output box_cols,
                    output config_error, input ready);
    modport sink   (input valid, input written, input map_row, input map_col,
                    input mapped_index, input box_rows, input box_cols,
                    input config_error, output ready);
endinterface

>>> rtl/spr_regs.sv
module spr_regs import spr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_MULT   = MAX_MULT_DEF,
    localparam int MW        = $clog2(MAX_MULT + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    output logic [COORD_BITS-1:0] o_xmin,
    output logic [COORD_BITS-1:0] o_ymin,
    output logic [COORD_BITS:0]   o_cols,
    output logic [MW-1:0]         o_mult,
    output logic                  o_inv,
    output logic [SHIFT_W-1:0]    o_shift
);

    logic [COORD_BITS-1:0] r_xmin;
    logic [COORD_BITS-1:0] r_ymin;
    logic [COORD_BITS:0]   r_cols;
    logic [MULT_REG_W-1:0] r_mult;
    logic                  r_inv;
    logic [SHIFT_W-1:0]    r_shift;
    t_reg                  w_sel;
    logic                  w_wr;

    assign w_sel  = t_reg'(paddr[APB_AW-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xmin  <= '0;
            r_ymin  <= '0;
            r_cols  <= (COORD_BITS + 1)'(1);
            r_mult  <= MULT_REG_W'(1);
            r_inv   <= 1'b0;
            r_shift <= '0;
        end else if (w_wr) begin
            case (w_sel)
                REG_XMIN:  r_xmin  <= pwdata[COORD_BITS-1:0];
                REG_YMIN:  r_ymin  <= pwdata[COORD_BITS-1:0];
                REG_COLS:  r_cols  <= pwdata[COORD_BITS:0];
                REG_MULT:  r_mult  <= pwdata[MULT_REG_W-1:0];
                REG_INV:   r_inv   <= pwdata[0];
                REG_SHIFT: r_shift <= pwdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            REG_XMIN:  prdata = APB_DW'(r_xmin);
            REG_YMIN:  prdata = APB_DW'(r_ymin);
            REG_COLS:  prdata = APB_DW'(r_cols);
            REG_MULT:  prdata = APB_DW'(r_mult);
            REG_INV:   prdata = APB_DW'(r_inv);
            REG_SHIFT: prdata = APB_DW'(r_shift);
            default:   prdata = '0;
        endcase
    end

    // zero acts as one, large values clamp
    always_comb begin
        if (r_mult == '0) begin
            o_mult = MW'(1);
        end else if (int'(r_mult) > MAX_MULT) begin
            o_mult = MW'(MAX_MULT);
        end else begin
            o_mult = MW'(r_mult);
        end
    end

    assign o_xmin  = r_xmin;
    assign o_ymin  = r_ymin;
    assign o_cols  = r_cols;
    assign o_inv   = r_inv;
    assign o_shift = r_shift;

endmodule

>>> rtl/spr_sdiv.sv
module spr_sdiv import spr_pkg::*; #(
    parameter int N  = COORD_BITS_DEF + 1,
    parameter int MW = $clog2(MAX_MULT_DEF + 1)
) (
    input  logic          i_clk,
    input  logic          i_start,
    input  logic          i_step,
    input  logic [N-1:0]  i_dividend,
    input  logic [MW-1:0] i_divisor,
    output logic [N-1:0]  o_quot,
    output logic [MW-1:0] o_rem
);

    logic [N-1:0]  r_q;
    logic [MW-1:0] r_rem;
    logic [MW:0]   w_trial;
    logic          w_ge;
    logic [MW-1:0] n_rem;

    // restoring division, one quotient bit per step, msb first
    assign w_trial = {r_rem, r_q[N-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};

    always_comb begin
        if (w_ge) begin
            n_rem = MW'(w_trial - {1'b0, i_divisor});
        end else begin
            n_rem = w_trial[MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (i_step) begin
            r_q   <= {r_q[N-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

>>> rtl/spr_smul.sv
module spr_smul import spr_pkg::*; #(
    parameter int DW = COORD_BITS_DEF + 1,
    parameter int MW = $clog2(MAX_MULT_DEF + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_start,
    input  logic                    i_step,
    input  logic signed [DW-1:0]    i_a,
    input  logic [MW-1:0]           i_b,
    output logic signed [DW+MW-1:0] o_prod
);

    logic signed [DW-1:0]    r_a;
    logic [MW-1:0]           r_b;
    logic signed [DW+MW-1:0] r_acc;
    logic signed [DW+MW-1:0] w_addend;

    // shift-add over the multiplier bits, msb first
    assign w_addend = r_b[MW-1] ? {{MW{r_a[DW-1]}}, r_a} : '0;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (i_step) begin
            r_acc <= (r_acc <<< 1) + w_addend;
            r_b   <= r_b << 1;
        end
    end

    assign o_prod = r_acc;

endmodule

>>> rtl/spr_box.sv
module spr_box import spr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_box_cmd              i_cmd,
    input  logic [ROW_W-1:0]      i_row,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [IDX_W-1:0]      i_uidx,
    output logic                  o_written,
    output logic [ROW_W-1:0]      o_map_row,
    output logic [COORD_BITS-1:0] o_map_col,
    output logic [IDX_W-1:0]      o_map_idx,
    output logic [ROW_W-1:0]      o_box_rows,
    output logic [COORD_BITS:0]   o_box_cols
);

    logic [ROW_W-1:0]      r_row_lo, n_row_lo;
    logic [ROW_W-1:0]      r_row_hi, n_row_hi;
    logic [COORD_BITS-1:0] r_col_lo, n_col_lo;
    logic [COORD_BITS-1:0] r_col_hi, n_col_hi;
    logic                  r_empty, n_empty;
    logic                  r_written, n_written;
    logic [ROW_W-1:0]      r_mrow, n_mrow;
    logic [COORD_BITS-1:0] r_mcol, n_mcol;
    logic [IDX_W-1:0]      r_midx, n_midx;
    logic                  w_inside;

    assign w_inside = !r_empty && (i_row >= r_row_lo) && (i_row <= r_row_hi)
                      && (i_col >= r_col_lo) && (i_col <= r_col_hi);

    always_comb begin
        n_row_lo  = r_row_lo;
        n_row_hi  = r_row_hi;
        n_col_lo  = r_col_lo;
        n_col_hi  = r_col_hi;
        n_empty   = r_empty;
        n_written = 1'b0;
        n_mrow    = '0;
        n_mcol    = '0;
        n_midx    = '0;
        case (i_cmd.op)
            OP_CLEAR: begin
                n_row_lo = '1;
                n_row_hi = '0;
                n_col_lo = '1;
                n_col_hi = '0;
                n_empty  = 1'b1;
            end
            OP_MEASURE: begin
                if (i_cmd.valid) begin
                    if (r_empty || i_row < r_row_lo) n_row_lo = i_row;
                    if (r_empty || i_row > r_row_hi) n_row_hi = i_row;
                    if (r_empty || i_col < r_col_lo) n_col_lo = i_col;
                    if (r_empty || i_col > r_col_hi) n_col_hi = i_col;
                    n_empty = 1'b0;
                end
            end
            OP_EMIT: begin
                if (i_cmd.valid && w_inside) begin
                    n_written = 1'b1;
                    n_mrow    = i_row - r_row_lo;
                    n_mcol    = i_col - r_col_lo;
                    n_midx    = i_uidx;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_lo <= '1;
            r_row_hi <= '0;
            r_col_lo <= '1;
            r_col_hi <= '0;
            r_empty  <= 1'b1;
        end else if (i_cmd.step) begin
            r_row_lo <= n_row_lo;
            r_row_hi <= n_row_hi;
            r_col_lo <= n_col_lo;
            r_col_hi <= n_col_hi;
            r_empty  <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_written <= n_written;
            r_mrow    <= n_mrow;
            r_mcol    <= n_mcol;
            r_midx    <= n_midx;
        end
    end

    assign o_written  = r_written;
    assign o_map_row  = r_mrow;
    assign o_map_col  = r_mcol;
    assign o_map_idx  = r_midx;
    assign o_box_rows = r_empty ? '0 : ROW_W'(r_row_hi - r_row_lo + ROW_W'(1));
    assign o_box_cols = r_empty ? '0
                                : ({1'b0, r_col_hi} - {1'b0, r_col_lo} + (COORD_BITS + 1)'(1));

endmodule

>>> rtl/strixel_pixel_remap.sv
// Strixel pixel remap. Each pixel transaction (opcode, pixel_x, pixel_y, user_index)
// gives exactly one result transaction. Clear empties the bounding box, measure grows
// it over valid pixels, emit reports the pixel's offset inside the box with its user
// index; box_rows/box_cols always show the box after the transaction and config_error
// flags a group width not divisible by the effective multiplicator. One transaction is
// in flight at a time. The bit-serial dividers produce one quotient bit per cycle for
// the strixel column and the strixel width, while a serial shift-add multiplier forms
// the row in the same cycles. A finished result waits in an output register, so the
// next pixel is taken while it is unread.
// Registers: 0 group_xmin, 1 group_ymin, 2 group_cols, 3 multiplicator, 4 inverse_order,
// 5 row_shift at byte addresses 4*index; the user must write them only while idle, as the block does not enforce it.
module strixel_pixel_remap import spr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_MULT   = MAX_MULT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    spr_in_if.sink            i_in,
    spr_out_if.source         o_out
);

    localparam int MW    = $clog2(MAX_MULT + 1);
    localparam int DIV_N = COORD_BITS + 1;
    localparam int STEPS = (DIV_N > MW) ? DIV_N : MW;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int PW    = DIV_N + MW;
    localparam int RSW   = ((PW > SHIFT_W + 1) ? PW : SHIFT_W + 1) + 2;

    logic [COORD_BITS-1:0] w_xmin, w_ymin;
    logic [COORD_BITS:0]   w_cols;
    logic [MW-1:0]         w_mult;
    logic                  w_inv;
    logic [SHIFT_W-1:0]    w_shift;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt;

    logic w_accept, w_in_ready, w_div_step, w_mul_step, w_loc, w_box, w_load;

    t_op                r_op;
    logic [IDX_W-1:0]   r_uidx;
    logic               r_dx_ok;
    logic [COORD_BITS:0] w_dx, w_dy;

    logic [DIV_N-1:0]       w_q_dx, w_q_cols;
    logic [MW-1:0]          w_rem_dx, w_rem_cols;
    logic signed [PW-1:0]   w_prod;
    logic [MW-1:0]          w_sub;
    logic signed [RSW-1:0]  w_r;
    logic                   w_row_ok, w_col_ok;

    logic                  r_valid;
    logic [ROW_W-1:0]      r_row;
    logic [COORD_BITS-1:0] r_col;
    logic                  r_cfg_err;

    t_box_cmd              w_cmd;
    logic                  w_b_written;
    logic [ROW_W-1:0]      w_b_mrow, w_b_rows;
    logic [COORD_BITS-1:0] w_b_mcol;
    logic [IDX_W-1:0]      w_b_midx;
    logic [COORD_BITS:0]   w_b_cols;

    logic                  r_out_vld;
    logic                  r_o_written;
    logic [ROW_W-1:0]      r_o_mrow, r_o_rows;
    logic [COORD_BITS-1:0] r_o_mcol;
    logic [IDX_W-1:0]      r_o_midx;
    logic [COORD_BITS:0]   r_o_cols;
    logic                  r_o_err;

    spr_regs #(
        .COORD_BITS (COORD_BITS),
        .MAX_MULT   (MAX_MULT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_xmin  (w_xmin),
        .o_ymin  (w_ymin),
        .o_cols  (w_cols),
        .o_mult  (w_mult),
        .o_inv   (w_inv),
        .o_shift (w_shift)
    );

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RUN) begin
                r_cnt <= r_cnt + CW'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in.valid) n_state = ST_RUN;
            ST_RUN:  if (r_cnt == CW'(STEPS - 1)) n_state = ST_LOC;
            ST_LOC:  n_state = ST_BOX;
            ST_BOX:  n_state = ST_DONE;
            ST_DONE: if (!r_out_vld || o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_div_step = 1'b0;
        w_mul_step = 1'b0;
        w_loc      = 1'b0;
        w_box      = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            ST_IDLE: w_in_ready = 1'b1;
            ST_RUN: begin
                w_div_step = r_cnt < CW'(DIV_N);
                w_mul_step = r_cnt < CW'(MW);
            end
            ST_LOC:  w_loc  = 1'b1;
            ST_BOX:  w_box  = 1'b1;
            ST_DONE: w_load = !r_out_vld || o_out.ready;
            default: ;
        endcase
    end

    assign i_in.ready = w_in_ready;
    assign w_accept   = i_in.valid && w_in_ready;

    // offsets from the group origin
    assign w_dx = {1'b0, i_in.pixel_x} - {1'b0, w_xmin};
    assign w_dy = {1'b0, i_in.pixel_y} - {1'b0, w_ymin};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= t_op'(i_in.opcode);
            r_uidx  <= i_in.user_index;
            r_dx_ok <= !w_dx[COORD_BITS];
        end
    end

    spr_sdiv #(.N(DIV_N), .MW(MW)) u_div_col (
        .i_clk      (i_clk),
        .i_start    (w_accept),
        .i_step     (w_div_step),
        .i_dividend ({1'b0, w_dx[COORD_BITS-1:0]}),
        .i_divisor  (w_mult),
        .o_quot     (w_q_dx),
        .o_rem      (w_rem_dx)
    );

    spr_sdiv #(.N(DIV_N), .MW(MW)) u_div_width (
        .i_clk      (i_clk),
        .i_start    (w_accept),
        .i_step     (w_div_step),
        .i_dividend (w_cols),
        .i_divisor  (w_mult),
        .o_quot     (w_q_cols),
        .o_rem      (w_rem_cols)
    );

    spr_smul #(.DW(DIV_N), .MW(MW)) u_mul (
        .i_clk   (i_clk),
        .i_start (w_accept),
        .i_step  (w_mul_step),
        .i_a     ($signed(w_dy)),
        .i_b     (w_mult),
        .o_prod  (w_prod)
    );

    // strixel row and validity
    assign w_sub    = w_inv ? (w_mult - MW'(1) - w_rem_dx) : w_rem_dx;
    assign w_r      = RSW'(w_prod) + $signed(RSW'({1'b0, w_sub}))
                      + $signed(RSW'({1'b0, w_shift}));
    assign w_row_ok = !w_r[RSW-1] && (int'(w_r) <= ROW_MAX);
    assign w_col_ok = w_q_dx < w_q_cols;

    always_ff @(posedge i_clk) begin
        if (w_loc) begin
            r_valid   <= r_dx_ok && w_row_ok && w_col_ok;
            r_row     <= ROW_W'($unsigned(w_r));
            r_col     <= w_q_dx[COORD_BITS-1:0];
            r_cfg_err <= |w_rem_cols;
        end
    end

    assign w_cmd.step  = w_box;
    assign w_cmd.op    = r_op;
    assign w_cmd.valid = r_valid;

    spr_box #(.COORD_BITS(COORD_BITS)) u_box (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_row      (r_row),
        .i_col      (r_col),
        .i_uidx     (r_uidx),
        .o_written  (w_b_written),
        .o_map_row  (w_b_mrow),
        .o_map_col  (w_b_mcol),
        .o_map_idx  (w_b_midx),
        .o_box_rows (w_b_rows),
        .o_box_cols (w_b_cols)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_written <= w_b_written;
            r_o_mrow    <= w_b_mrow;
            r_o_mcol    <= w_b_mcol;
            r_o_midx    <= w_b_midx;
            r_o_rows    <= w_b_rows;
            r_o_cols    <= w_b_cols;
            r_o_err     <= r_cfg_err;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.written      = r_o_written;
    assign o_out.map_row      = r_o_mrow;
    assign o_out.map_col      = r_o_mcol;
    assign o_out.mapped_index = r_o_midx;
    assign o_out.box_rows     = r_o_rows;
    assign o_out.box_cols     = r_o_cols;
    assign o_out.config_error = r_o_err;

endmodule

>>> rtl/spr_chk.sv
module spr_chk import spr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic                  i_written,
    input logic [ROW_W-1:0]      i_map_row,
    input logic [COORD_BITS-1:0] i_map_col,
    input logic [IDX_W-1:0]      i_mapped_index,
    input logic [COORD_BITS:0]   i_box_cols
);

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one pixel in flight, so an accept closes the input for the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted back to back");

    // position fields are zero when nothing was placed
    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_written) |->
            (i_map_row == '0 && i_map_col == '0 && i_mapped_index == '0))
        else $error("position fields set without a write");

    // a placed pixel's column lies inside the reported box
    a_col_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_written) |-> ({1'b0, i_map_col} < i_box_cols))
        else $error("map column outside box");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_mapped_index)))
        else $error("stalled result changed");

endmodule

bind strixel_pixel_remap spr_chk #(.COORD_BITS(COORD_BITS)) u_spr_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_written      (o_out.written),
    .i_map_row      (o_out.map_row),
    .i_map_col      (o_out.map_col),
    .i_mapped_index (o_out.mapped_index),
    .i_box_cols     (o_out.box_cols)
);

>>> bench/strixel_pixel_remap_tb.sv
`timescale 1ns / 100ps

module strixel_pixel_remap_tb;
    import spr_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int IDLE_PCT    = 19;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;
    localparam int QUIET_LIMIT = 3000;
    localparam int REPORT_MAX  = 200;

    typedef struct packed {
        t_op         op;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [19:0] idx;
    } t_pixel_txn;

    typedef struct packed {
        logic              written;
        logic [ROW_W-1:0]  map_row;
        logic [9:0]        map_col;
        logic [IDX_W-1:0]  mapped_index;
        logic [ROW_W-1:0]  box_rows;
        logic [10:0]       box_cols;
        logic              config_error;
    } t_map_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    spr_in_if  pix_bus ();
    spr_out_if map_bus ();

    strixel_pixel_remap DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (pix_bus),
        .o_out   (map_bus)
    );

    // register shadow
    logic [9:0]  cfg_xmin;
    logic [9:0]  cfg_ymin;
    logic [10:0] cfg_cols;
    logic [4:0]  cfg_mult;
    logic        cfg_inv;
    logic [7:0]  cfg_shift;

    // bounding box shadow
    int box_row_lo;
    int box_row_hi;
    int box_col_lo;
    int box_col_hi;
    bit box_is_empty;

    t_pixel_txn  pixel_q[$];
    t_pixel_txn  pixel_cur;
    t_map_result remap_results_q[$];
    t_map_result map_want;

    int mismatch_count;
    int idle_pct;
    int hold_cnt;
    bit hold_req;
    int quiet_cycles;

    always #CLK_HALF i_clk = ~i_clk;

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    function automatic void clear_box();
        box_row_lo   = ROW_MAX;
        box_row_hi   = 0;
        box_col_lo   = (1 << COORD_BITS_DEF) - 1;
        box_col_hi   = 0;
        box_is_empty = 1'b1;
    endfunction

    function automatic t_map_result remap_pixel(t_pixel_txn p);
        int          m;
        int          dx;
        int          dy;
        int          sub;
        int          r;
        int          c;
        bit          ok;
        t_map_result res;
        m = (cfg_mult == 0) ? 1 : (int'(cfg_mult) > MAX_MULT_DEF) ? MAX_MULT_DEF
                                                                  : int'(cfg_mult);
        dx = int'(p.x) - int'(cfg_xmin);
        dy = int'(p.y) - int'(cfg_ymin);
        ok = (dx >= 0);
        r = 0;
        c = 0;
        if (ok) begin
            c = dx / m;
            sub = dx % m;
            if (cfg_inv) begin
                sub = m - 1 - sub;
            end
            r = dy * m + sub + int'(cfg_shift);
            if (r < 0 || r > ROW_MAX || c >= int'(cfg_cols) / m) begin
                ok = 1'b0;
            end
        end
        res = '0;
        case (p.op)
            OP_CLEAR: begin
                clear_box();
            end
            OP_MEASURE: begin
                if (ok) begin
                    if (box_is_empty || r < box_row_lo) box_row_lo = r;
                    if (box_is_empty || r > box_row_hi) box_row_hi = r;
                    if (box_is_empty || c < box_col_lo) box_col_lo = c;
                    if (box_is_empty || c > box_col_hi) box_col_hi = c;
                    box_is_empty = 1'b0;
                end
            end
            OP_EMIT: begin
                if (ok && !box_is_empty && r >= box_row_lo && r <= box_row_hi &&
                    c >= box_col_lo && c <= box_col_hi) begin
                    res.written      = 1'b1;
                    res.map_row      = ROW_W'(r - box_row_lo);
                    res.map_col      = 10'(c - box_col_lo);
                    res.mapped_index = p.idx;
                end
            end
            default: begin
            end
        endcase
        if (!box_is_empty) begin
            res.box_rows = ROW_W'(box_row_hi - box_row_lo + 1);
            res.box_cols = 11'(box_col_hi - box_col_lo + 1);
        end
        res.config_error = ((int'(cfg_cols) % m) != 0);
        return res;
    endfunction

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.valid <= 1'b0;
        end else begin
            if (pix_bus.valid && pix_bus.ready) begin
                remap_results_q.push_back(remap_pixel(pixel_cur));
            end
            if (!pix_bus.valid || pix_bus.ready) begin
                if (pixel_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    pixel_cur = pixel_q.pop_front();
                    pix_bus.valid      <= 1'b1;
                    pix_bus.opcode     <= pixel_cur.op;
                    pix_bus.pixel_x    <= pixel_cur.x;
                    pix_bus.pixel_y    <= pixel_cur.y;
                    pix_bus.user_index <= pixel_cur.idx;
                end else begin
                    pix_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            map_bus.ready <= 1'b0;
        end else begin
            if (map_bus.valid && map_bus.ready) begin
                if (remap_results_q.size() == 0) begin
                    report_mismatch("result transaction with nothing pending");
                end else begin
                    map_want = remap_results_q.pop_front();
                    check_field("written", map_bus.written, map_want.written);
                    check_field("map_row", map_bus.map_row, map_want.map_row);
                    check_field("map_col", map_bus.map_col, map_want.map_col);
                    check_field("mapped_index", map_bus.mapped_index,
                                map_want.mapped_index);
                    check_field("box_rows", map_bus.box_rows, map_want.box_rows);
                    check_field("box_cols", map_bus.box_cols, map_want.box_cols);
                    check_field("config_error", map_bus.config_error,
                                map_want.config_error);
                end
            end
            if (hold_req) begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                map_bus.ready <= 1'b0;
            end else begin
                map_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((pix_bus.valid && pix_bus.ready) || (map_bus.valid && map_bus.ready) ||
                (psel && penable && pwrite && pready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog expired at %0t", $time);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_reg(t_reg idx, logic [APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_XMIN:  cfg_xmin  = value[9:0];
            REG_YMIN:  cfg_ymin  = value[9:0];
            REG_COLS:  cfg_cols  = value[10:0];
            REG_MULT:  cfg_mult  = value[4:0];
            REG_INV:   cfg_inv   = value[0];
            REG_SHIFT: cfg_shift = value[7:0];
            default: begin
            end
        endcase
    endtask

    task automatic set_group(int xmin, int ymin, int cols, int mult, int inv, int shift);
        write_reg(REG_XMIN, xmin);
        write_reg(REG_YMIN, ymin);
        write_reg(REG_COLS, cols);
        write_reg(REG_MULT, mult);
        write_reg(REG_INV, inv);
        write_reg(REG_SHIFT, shift);
    endtask

    task automatic set_random_group();
        int mult;
        mult = $urandom_range(1, MAX_MULT_DEF);
        set_group($urandom_range(0, 1023), $urandom_range(0, 1023),
                  ($urandom_range(0, 1) == 1) ? mult * $urandom_range(1, 64)
                                             : $urandom_range(1, 1024),
                  mult, $urandom_range(0, 1), $urandom_range(0, 255));
    endtask

    task automatic push_pixel(t_op op, int x, int y, int idx);
        t_pixel_txn p;
        p.op  = op;
        p.x   = 10'(x);
        p.y   = 10'(y);
        p.idx = 20'(idx);
        pixel_q.push_back(p);
    endtask

    function automatic int near_x();
        int span;
        int v;
        span = (cfg_cols > 64) ? 64 : int'(cfg_cols);
        v = int'(cfg_xmin) + $urandom_range(0, span + 1) - 1;
        if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1023);
        return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
    endfunction

    function automatic int near_y();
        int v;
        v = int'(cfg_ymin) + $urandom_range(0, 8) - 1;
        if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1023);
        return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
    endfunction

    // mostly clear / measure / emit runs with random content, some noise
    task automatic queue_random(int count);
        int left;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 99) < 15) begin
                push_pixel(t_op'($urandom_range(0, 3)), $urandom_range(0, 1023),
                           $urandom_range(0, 1023), $urandom_range(0, 20'hFFFFF));
                left--;
            end else begin
                push_pixel(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 20'hFFFFF));
                left--;
                repeat ($urandom_range(1, 6)) begin
                    push_pixel(OP_MEASURE, near_x(), near_y(), $urandom_range(0, 20'hFFFFF));
                    left--;
                end
                repeat ($urandom_range(1, 8)) begin
                    push_pixel(OP_EMIT, near_x(), near_y(), $urandom_range(0, 20'hFFFFF));
                    left--;
                end
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || pix_bus.valid || remap_results_q.size() != 0);
    endtask

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pix_bus.valid      = 1'b0;
        pix_bus.opcode     = OP_CLEAR;
        pix_bus.pixel_x    = '0;
        pix_bus.pixel_y    = '0;
        pix_bus.user_index = '0;
        map_bus.ready      = 1'b0;
        cfg_xmin           = 10'd0;
        cfg_ymin           = 10'd0;
        cfg_cols           = 11'd1;
        cfg_mult           = 5'd1;
        cfg_inv            = 1'b0;
        cfg_shift          = 8'd0;
        mismatch_count     = 0;
        idle_pct           = IDLE_PCT;
        hold_cnt           = 0;
        hold_req           = 1'b0;
        quiet_cycles       = 0;
        clear_box();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: strixel width 16, four columns per strixel
        set_group(100, 50, 64, 4, 0, 10);
        @(negedge i_clk);
        push_pixel(OP_EMIT, 120, 60, 123);
        push_pixel(OP_MEASURE, 110, 60, 0);
        push_pixel(OP_MEASURE, 150, 70, 0);
        push_pixel(OP_EMIT, 120, 65, 20'hFFFFF);
        push_pixel(OP_EMIT, 130, 60, 0);
        push_pixel(OP_EMIT, 170, 60, 20'h12345);
        push_pixel(OP_MEASURE, 50, 60, 7);
        push_pixel(OP_MEASURE, 1023, 1023, 20'hFFFFF);
        push_pixel(OP_MEASURE, 100, 0, 1);
        push_pixel(OP_MEASURE, 0, 0, 0);
        push_pixel(OP_MEASURE, 163, 1023, 2);
        push_pixel(OP_EMIT, 163, 1023, 20'hAAAAA);
        push_pixel(OP_NONE, 1023, 1023, 20'hFFFFF);
        push_pixel(OP_EMIT, 101, 51, 20'h55555);
        push_pixel(OP_EMIT, 100, 50, 20'h00001);
        push_pixel(OP_CLEAR, 0, 0, 0);
        push_pixel(OP_EMIT, 110, 60, 1);
        wait_drained();

        set_random_group();
        @(negedge i_clk);
        queue_random(60);
        wait_drained();

        set_group(1023, 1023, 2047, 31, 1, 255);
        @(negedge i_clk);
        queue_random(40);
        wait_drained();

        set_group(0, 0, 1024, 1, 0, 0);
        @(negedge i_clk);
        idle_pct = 0;
        queue_random(60);
        wait_drained();
        idle_pct = IDLE_PCT;

        set_group(5, 900, 0, 0, 1, 3);
        @(negedge i_clk);
        queue_random(30);
        wait_drained();

        // indivisible width while the result side holds off
        set_group(200, 10, 10, 3, 1, 17);
        @(negedge i_clk);
        hold_req = 1'b1;
        queue_random(60);
        wait_drained();

        set_group(512, 300, 160, 16, 0, 128);
        @(negedge i_clk);
        queue_random(70);
        wait_drained();

        repeat (2) begin
            set_random_group();
            @(negedge i_clk);
            queue_random(60);
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (remap_results_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", remap_results_q.size()));
        end
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
